// ===== src/bcl_pkg.sv =====
// ----------------------------------------------------------------------------
// Barycentric interpolation package
// Shared widths, codes and types for the interpolation lanes and merge stage.
// ----------------------------------------------------------------------------
package bcl_pkg;

  localparam int TIME_W    = 17;
  localparam int VAL_W     = 32;
  localparam int FRAC_W    = 16;
  localparam int MAX_NODES = 4;
  localparam int DIV_W     = VAL_W + FRAC_W;
  localparam int Q_W       = DIV_W + 1;
  localparam int NUM_W     = Q_W + VAL_W;
  localparam int NSUM_W    = NUM_W + 2;
  localparam int DSUM_W    = Q_W + 2;
  localparam int LANE_LAT  = DIV_W + 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_W0   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_W1   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_W2   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_W3   = 3'd7;

  localparam logic signed [VAL_W-1:0] SAT_POS = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] SAT_NEG = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ST_COMP = 2'd0,
    ST_HIT  = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic signed [Q_W-1:0]   den_t;

  // result decided up front (hold mode or exact node hit)
  typedef struct packed {
    logic                    spec;
    logic signed [VAL_W-1:0] val;
    status_t                 st;
  } side_t;

endpackage

// ===== src/bcl_lane.sv =====
// ----------------------------------------------------------------------------
// Interpolation lane
// Pipelined q = w*2^16 / (t - tau) one quotient bit per stage, then q*v.
// ----------------------------------------------------------------------------
module bcl_lane
  import bcl_pkg::*;
(
  input  logic                    clk,
  input  logic                    ce,
  input  logic [TIME_W-1:0]       in_time,
  input  logic [TIME_W-1:0]       node_time,
  input  logic signed [VAL_W-1:0] weight,
  input  logic signed [VAL_W-1:0] value,
  output num_t                    num,
  output den_t                    den
);

  localparam int LO_W = 24;
  localparam int HI_W = Q_W - LO_W;

  logic [DIV_W-1:0]        a_r   [DIV_W+1];
  logic [TIME_W-1:0]       b_r   [DIV_W+1];
  logic [TIME_W-1:0]       rem_r [DIV_W+1];
  logic [DIV_W-1:0]        q_r   [DIV_W+1];
  logic                    neg_r [DIV_W+1];
  logic signed [VAL_W-1:0] v_r   [DIV_W+1];

  logic [TIME_W:0]   diff;
  logic [TIME_W-1:0] dmag;
  logic [VAL_W-1:0]  wmag;

  always_comb begin
    diff = {1'b0, in_time} - {1'b0, node_time};
    dmag = diff[TIME_W] ? TIME_W'(~diff + 1'b1) : diff[TIME_W-1:0];
    wmag = weight[VAL_W-1] ? (~$unsigned(weight)) + 1'b1 : $unsigned(weight);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_r[0]   <= {wmag, {FRAC_W{1'b0}}};
      b_r[0]   <= dmag;
      rem_r[0] <= '0;
      q_r[0]   <= '0;
      neg_r[0] <= weight[VAL_W-1] ^ diff[TIME_W];
      v_r[0]   <= value;
    end
  end

  for (genvar s = 0; s < DIV_W; s++) begin : g_div
    logic [TIME_W:0] trial;
    logic            ge;
    always_comb begin
      trial = {rem_r[s], a_r[s][DIV_W-1]};
      ge    = trial >= {1'b0, b_r[s]};
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[s+1] <= ge ? TIME_W'(trial - {1'b0, b_r[s]}) : trial[TIME_W-1:0];
        a_r[s+1]   <= a_r[s] << 1;
        b_r[s+1]   <= b_r[s];
        q_r[s+1]   <= {q_r[s][DIV_W-2:0], ge};
        neg_r[s+1] <= neg_r[s];
        v_r[s+1]   <= v_r[s];
      end
    end
  end

  logic signed [Q_W-1:0]        qs;
  logic signed [Q_W-1:0]        qs_r;
  logic signed [LO_W+VAL_W:0]   plo_r;
  logic signed [HI_W+VAL_W-1:0] phi_r;
  num_t                         num_r;
  den_t                         den_r;

  always_comb begin
    qs = neg_r[DIV_W] ? -$signed({1'b0, q_r[DIV_W]}) : $signed({1'b0, q_r[DIV_W]});
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      plo_r <= $signed({1'b0, qs[LO_W-1:0]}) * v_r[DIV_W];
      phi_r <= $signed(qs[Q_W-1:LO_W]) * v_r[DIV_W];
      qs_r  <= qs;
      num_r <= (NUM_W'(phi_r) <<< LO_W) + NUM_W'(plo_r);
      den_r <= qs_r;
    end
  end

  assign num = num_r;
  assign den = den_r;

endmodule

// ===== src/bcl_merge.sv =====
// ----------------------------------------------------------------------------
// Interpolation merge
// Sums lane numerators and denominators, divides, saturates, picks result.
// ----------------------------------------------------------------------------
module bcl_merge
  import bcl_pkg::*;
#(
  parameter int LANES = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ce,
  input  logic                    in_vld,
  input  side_t                   side,
  input  num_t                    num [LANES],
  input  den_t                    den [LANES],
  output logic                    out_vld,
  output logic signed [VAL_W-1:0] out_value,
  output status_t                 out_status
);

  localparam int MSTG = 3 + VAL_W;
  localparam int LAST = MSTG - 1;

  logic  vld_r  [MSTG];
  side_t side_r [MSTG];

  logic signed [NSUM_W-1:0] nsum_nxt, nsum_r;
  logic signed [DSUM_W-1:0] dsum_nxt, dsum_r;

  logic [NSUM_W-1:0] rem_r  [MSTG];
  logic [VAL_W-1:0]  q_r    [MSTG];
  logic [DSUM_W-1:0] dmag_r [MSTG];
  logic              neg_r  [MSTG];
  logic              dz_r   [MSTG];
  logic              over_r [MSTG];

  always_comb begin
    nsum_nxt = '0;
    dsum_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      nsum_nxt = nsum_nxt + NSUM_W'(num[i]);
      dsum_nxt = dsum_nxt + DSUM_W'(den[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MSTG; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (ce) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < MSTG; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side_r[0] <= side;
      for (int k = 1; k < MSTG; k++) begin
        side_r[k] <= side_r[k-1];
      end
      nsum_r    <= nsum_nxt;
      dsum_r    <= dsum_nxt;
      rem_r[1]  <= nsum_r[NSUM_W-1] ? $unsigned(-nsum_r) : $unsigned(nsum_r);
      dmag_r[1] <= dsum_r[DSUM_W-1] ? $unsigned(-dsum_r) : $unsigned(dsum_r);
      neg_r[1]  <= nsum_r[NSUM_W-1] ^ dsum_r[DSUM_W-1];
      dz_r[1]   <= dsum_r == '0;
      rem_r[2]  <= rem_r[1];
      q_r[2]    <= '0;
      dmag_r[2] <= dmag_r[1];
      neg_r[2]  <= neg_r[1];
      dz_r[2]   <= dz_r[1];
      over_r[2] <= rem_r[1] >= (NSUM_W'(dmag_r[1]) << VAL_W);
    end
  end

  for (genvar k = 0; k < VAL_W; k++) begin : g_div
    localparam int BIT = VAL_W - 1 - k;
    logic [NSUM_W-1:0] sh;
    logic              ge;
    always_comb begin
      sh = NSUM_W'(dmag_r[k+2]) << BIT;
      ge = rem_r[k+2] >= sh;
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k+3]  <= ge ? rem_r[k+2] - sh : rem_r[k+2];
        q_r[k+3]    <= {q_r[k+2][VAL_W-2:0], ge};
        dmag_r[k+3] <= dmag_r[k+2];
        neg_r[k+3]  <= neg_r[k+2];
        dz_r[k+3]   <= dz_r[k+2];
        over_r[k+3] <= over_r[k+2];
      end
    end
  end

  logic signed [VAL_W-1:0] value_nxt, value_r;
  status_t                 status_nxt, status_r;
  logic                    out_vld_r;

  always_comb begin
    if (side_r[LAST].spec) begin
      value_nxt  = side_r[LAST].val;
      status_nxt = side_r[LAST].st;
    end else if (dz_r[LAST]) begin
      value_nxt  = '0;
      status_nxt = ST_ZERO;
    end else if (!neg_r[LAST] && (over_r[LAST] || q_r[LAST][VAL_W-1])) begin
      value_nxt  = SAT_POS;
      status_nxt = ST_SAT;
    end else if (neg_r[LAST] && (over_r[LAST] ||
                 (q_r[LAST][VAL_W-1] && q_r[LAST][VAL_W-2:0] != '0))) begin
      value_nxt  = SAT_NEG;
      status_nxt = ST_SAT;
    end else begin
      value_nxt  = neg_r[LAST] ? -$signed(q_r[LAST]) : $signed(q_r[LAST]);
      status_nxt = ST_COMP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ce) begin
      out_vld_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_vld    = out_vld_r;
  assign out_value  = value_r;
  assign out_status = status_r;

endmodule

// ===== src/barycentric_interpolation_top.sv =====
// ----------------------------------------------------------------------------
// Barycentric Lagrange interpolation
// One row of node values in, interpolant at the given time out.
//
//   port group   dir   handshake        payload
//   in_*         in    valid / ready    eval_time, value_at_node_0..3
//   out_*        out   valid / ready    interpolated_value, status
//   cfg_*        in    write enable     index, 32-bit data
//
// One item per cycle while the output is not stalled. The lanes hold the
// 48-stage quotient pipeline for w/(t-tau) plus split multiply. The merge has
// sums, magnitude, overflow test, 32-stage final division, output register.
// Synchronous active-low reset clears valids and config to defaults.
// A stalled output freezes the whole pipeline; in_ready follows.
// ----------------------------------------------------------------------------
module barycentric_interpolation_top
  import bcl_pkg::*;
#(
  parameter int NODE_COUNT = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [TIME_W-1:0]        in_eval_time,
  input  logic signed [VAL_W-1:0]  in_value_at_node_0,
  input  logic signed [VAL_W-1:0]  in_value_at_node_1,
  input  logic signed [VAL_W-1:0]  in_value_at_node_2,
  input  logic signed [VAL_W-1:0]  in_value_at_node_3,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VAL_W-1:0]  out_interpolated_value,
  output logic [1:0]               out_status,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [VAL_W-1:0]         cfg_wdata
);

  localparam int NC = (NODE_COUNT < 2) ? 2 : (NODE_COUNT > MAX_NODES) ? MAX_NODES : NODE_COUNT;

  logic                    hold_r;
  logic [TIME_W-1:0]       tau_r [MAX_NODES];
  logic signed [VAL_W-1:0] w_r   [MAX_NODES];
  logic signed [VAL_W-1:0] vals  [MAX_NODES];
  logic                    ce;
  logic                    accept;

  assign ce       = !out_valid || out_ready;
  assign in_ready = ce;
  assign accept   = in_valid && ce;

  assign vals[0] = in_value_at_node_0;
  assign vals[1] = in_value_at_node_1;
  assign vals[2] = in_value_at_node_2;
  assign vals[3] = in_value_at_node_3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b1;
      for (int i = 0; i < MAX_NODES; i++) begin
        tau_r[i] <= '0;
        w_r[i]   <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOLD: hold_r   <= cfg_wdata[0];
        CFG_TAU1: tau_r[1] <= cfg_wdata[TIME_W-1:0];
        CFG_TAU2: tau_r[2] <= cfg_wdata[TIME_W-1:0];
        CFG_TAU3: tau_r[3] <= cfg_wdata[TIME_W-1:0];
        CFG_W0:   w_r[0]   <= $signed(cfg_wdata);
        CFG_W1:   w_r[1]   <= $signed(cfg_wdata);
        CFG_W2:   w_r[2]   <= $signed(cfg_wdata);
        CFG_W3:   w_r[3]   <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // hold mode and exact node hits bypass the arithmetic; first node wins
  side_t side_nxt;
  always_comb begin
    side_nxt.spec = hold_r;
    side_nxt.val  = vals[0];
    side_nxt.st   = ST_COMP;
    if (!hold_r) begin
      for (int i = NC - 1; i >= 0; i--) begin
        if (in_eval_time == tau_r[i]) begin
          side_nxt.spec = 1'b1;
          side_nxt.val  = vals[i];
          side_nxt.st   = ST_HIT;
        end
      end
    end
  end

  logic  sv_r   [LANE_LAT];
  side_t side_r [LANE_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LANE_LAT; k++) begin
        sv_r[k] <= 1'b0;
      end
    end else if (ce) begin
      sv_r[0] <= accept;
      for (int k = 1; k < LANE_LAT; k++) begin
        sv_r[k] <= sv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < LANE_LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  num_t lane_num [NC];
  den_t lane_den [NC];

  for (genvar i = 0; i < NC; i++) begin : g_lane
    bcl_lane u_lane (
      .clk       (clk),
      .ce        (ce),
      .in_time   (in_eval_time),
      .node_time (tau_r[i]),
      .weight    (w_r[i]),
      .value     (vals[i]),
      .num       (lane_num[i]),
      .den       (lane_den[i])
    );
  end

  status_t merge_status;

  bcl_merge #(
    .LANES (NC)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ce         (ce),
    .in_vld     (sv_r[LANE_LAT-1]),
    .side       (side_r[LANE_LAT-1]),
    .num        (lane_num),
    .den        (lane_den),
    .out_vld    (out_valid),
    .out_value  (out_interpolated_value),
    .out_status (merge_status)
  );

  assign out_status = merge_status;

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && merge_status == ST_ZERO |-> out_interpolated_value == '0)
    else $error("zero denominator item with nonzero value");

  a_sat_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && merge_status == ST_SAT |->
      out_interpolated_value == SAT_POS || out_interpolated_value == SAT_NEG)
    else $error("saturated item not at a rail");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> $stable(sv_r[LANE_LAT-1]))
    else $error("pipeline advanced during stall");

endmodule
